### hw/rtl/ajrb_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the audio jitter ring buffer.
package ajrb_pkg;

   localparam int RING_DEPTH = 32768;
   localparam int PREFILL    = 4410;
   localparam int BLOCK_MAX  = 64;

   // The ring depth is a power of two, so pointers wrap by truncation.
   localparam int ADDR_W    = $clog2(RING_DEPTH);
   localparam int LEVEL_W   = $clog2(RING_DEPTH + 1);
   localparam int REG_W     = 16;
   localparam int CMP_W     = (LEVEL_W > REG_W) ? LEVEL_W : REG_W;
   localparam int SAMPLE_W  = 24;
   localparam int FRAME_W   = 4 * SAMPLE_W;
   localparam int BLOCK_W   = 7;
   localparam int CSR_IDX_W = 2;

   // Up to two commands queued and one streaming.
   localparam int QUEUE_DEPTH = 2;
   localparam int PEND_W      = $clog2((QUEUE_DEPTH + 1) * BLOCK_MAX + 1);

   localparam int PREFILL_LEVEL = (PREFILL > RING_DEPTH) ? RING_DEPTH : PREFILL;

   localparam logic [REG_W-1:0] TARGET_RESET = 16'd4410;
   localparam logic [REG_W-1:0] HIGH_RESET   = 16'd8820;
   localparam logic [REG_W-1:0] TRIM_RESET   = 16'd441;

   localparam logic [CSR_IDX_W-1:0] REG_TARGET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TRIM   = 2'd2;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_PULL = 1'b1;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_TRIM
   } front_state_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  base;
      logic [BLOCK_W-1:0] frames;
      logic               silent;
      logic [REG_W-1:0]   level;
   } cmd_type;

   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [FRAME_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### hw/rtl/audio_jitter_ring_buffer.sv
`timescale 1ns / 1ps
// Top level of the audio jitter ring buffer: front part, command queue, back part and frame RAM.
//
// An item is taken when start is high and busy is low. A push whose frame was stored with
// burst_end set is followed by the burst-end trim check in its own state, FRONT_TRIM. A pull
// is taken into a two-entry command queue; its block of 1 to 64 results then streams out at
// one frame per cycle through the queue, the back part's command register and the RAM's
// registered read, paced by the single read port of the frame RAM. Each result is on the
// rsp_ ports for exactly one cycle, marked by rsp_valid, and cannot be held off. busy is high
// during the trim check, while the command queue is full, and while the ring is so full that
// the next push's slot may still be waiting to be read for an earlier pull. No clearing pass
// is needed after reset: prefill slots read as silence until a push first overwrites them.
module audio_jitter_ring_buffer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_mode,
   input  logic signed [ajrb_pkg::SAMPLE_W-1:0]   req_in_ch0,
   input  logic signed [ajrb_pkg::SAMPLE_W-1:0]   req_in_ch1,
   input  logic signed [ajrb_pkg::SAMPLE_W-1:0]   req_in_ch2,
   input  logic signed [ajrb_pkg::SAMPLE_W-1:0]   req_in_ch3,
   input  logic                                   req_burst_end,
   input  logic [ajrb_pkg::BLOCK_W-1:0]           req_block_frames,
   output logic                                   rsp_valid,
   output logic signed [ajrb_pkg::SAMPLE_W-1:0]   rsp_out_ch0,
   output logic signed [ajrb_pkg::SAMPLE_W-1:0]   rsp_out_ch1,
   output logic signed [ajrb_pkg::SAMPLE_W-1:0]   rsp_out_ch2,
   output logic signed [ajrb_pkg::SAMPLE_W-1:0]   rsp_out_ch3,
   output logic                                   rsp_silent,
   output logic                                   rsp_block_last,
   output logic [ajrb_pkg::REG_W-1:0]             rsp_level_after,
   input  logic                                   csr_we,
   input  logic [ajrb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ajrb_pkg::REG_W-1:0]             csr_wdata
);

   ajrb_pkg::queue_status_type   q_status;
   ajrb_pkg::cmd_type            q_cmd;
   ajrb_pkg::cmd_type            q_head;
   logic                         q_push;
   logic                         q_pop;
   logic                         frame_taken;
   ajrb_pkg::ram_wr_type         ram_wr;
   logic [ajrb_pkg::LEVEL_W-1:0] low_written;
   logic                         rd_en;
   logic [ajrb_pkg::ADDR_W-1:0]  rd_addr;
   logic [ajrb_pkg::FRAME_W-1:0] rd_data;

   ajrb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_in_ch0       (req_in_ch0),
      .req_in_ch1       (req_in_ch1),
      .req_in_ch2       (req_in_ch2),
      .req_in_ch3       (req_in_ch3),
      .req_burst_end    (req_burst_end),
      .req_block_frames (req_block_frames),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_cmd            (q_cmd),
      .frame_taken      (frame_taken),
      .ram_wr           (ram_wr),
      .low_written      (low_written)
   );

   ajrb_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   ajrb_ram #(
      .WIDTH (ajrb_pkg::FRAME_W),
      .DEPTH (ajrb_pkg::RING_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ajrb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_head          (q_head),
      .q_status        (q_status),
      .q_pop           (q_pop),
      .low_written     (low_written),
      .frame_taken     (frame_taken),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_out_ch0     (rsp_out_ch0),
      .rsp_out_ch1     (rsp_out_ch1),
      .rsp_out_ch2     (rsp_out_ch2),
      .rsp_out_ch3     (rsp_out_ch3),
      .rsp_silent      (rsp_silent),
      .rsp_block_last  (rsp_block_last),
      .rsp_level_after (rsp_level_after)
   );

endmodule

### hw/rtl/ajrb_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module ajrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ajrb_cmd_queue.sv
`timescale 1ns / 1ps
// Two-entry command queue between the front and back parts.
module ajrb_cmd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ajrb_pkg::cmd_type         push_cmd,
   input  logic                      pop,
   output ajrb_pkg::cmd_type         head,
   output ajrb_pkg::queue_status_type status
);

   localparam int PTR_W = $clog2(ajrb_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ajrb_pkg::QUEUE_DEPTH + 1);

   ajrb_pkg::cmd_type entry_ff [ajrb_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(ajrb_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

### hw/rtl/ajrb_front.sv
`timescale 1ns / 1ps
// Front part: takes items, keeps the ring pointers and level, writes pushes, issues pulls.
module ajrb_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_mode,
   input  logic signed [ajrb_pkg::SAMPLE_W-1:0]   req_in_ch0,
   input  logic signed [ajrb_pkg::SAMPLE_W-1:0]   req_in_ch1,
   input  logic signed [ajrb_pkg::SAMPLE_W-1:0]   req_in_ch2,
   input  logic signed [ajrb_pkg::SAMPLE_W-1:0]   req_in_ch3,
   input  logic                                   req_burst_end,
   input  logic [ajrb_pkg::BLOCK_W-1:0]           req_block_frames,
   input  logic                                   csr_we,
   input  logic [ajrb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ajrb_pkg::REG_W-1:0]             csr_wdata,
   input  ajrb_pkg::queue_status_type             q_status,
   output logic                                   q_push,
   output ajrb_pkg::cmd_type                      q_cmd,
   input  logic                                   frame_taken,
   output ajrb_pkg::ram_wr_type                   ram_wr,
   output logic [ajrb_pkg::LEVEL_W-1:0]           low_written
);

   localparam int AW  = ajrb_pkg::ADDR_W;
   localparam int LW  = ajrb_pkg::LEVEL_W;
   localparam int CW  = ajrb_pkg::CMP_W;
   localparam int BW  = ajrb_pkg::BLOCK_W;
   localparam int PW  = ajrb_pkg::PEND_W;
   localparam int RW  = ajrb_pkg::REG_W;

   ajrb_pkg::front_state_type state_ff, state_in;
   logic [AW-1:0] read_ptr_ff, read_ptr_in;
   logic [AW-1:0] write_ptr_ff, write_ptr_in;
   logic [LW-1:0] fill_ff, fill_in;
   logic          buffering_ff, buffering_in;
   logic [LW-1:0] low_written_ff, low_written_in;
   logic [PW-1:0] pending_ff, pending_in;
   logic [LW-1:0] gap_ff, gap_in;
   logic [RW-1:0] target_ff, high_ff, trim_ff;

   logic          accept;
   logic          ring_hazard;
   logic [BW-1:0] frames;
   logic          silence;
   logic [CW-1:0] fill_cmp;
   logic [CW-1:0] excess;
   logic [CW-1:0] discard;
   logic [PW-1:0] pend_add;

   // A push is held while its slot may still hold frames the back part has not read.
   // Slots trimmed away while frames still wait to be read lie between those frames and
   // the write pointer, so they count against the free space until the back part catches up.
   assign ring_hazard = ((LW + 2)'(fill_ff) + (LW + 2)'(pending_ff) + (LW + 2)'(gap_ff))
                        >= (LW + 2)'(ajrb_pkg::RING_DEPTH);
   assign busy   = (state_ff == ajrb_pkg::FRONT_TRIM) || q_status.full
                   || ((pending_ff != '0) && ring_hazard);
   assign accept = start && !busy;
   assign fill_cmp = CW'(fill_ff);

   always_comb begin
      frames = req_block_frames;
      if (req_block_frames == '0) begin
         frames = BW'(1);
      end else if (req_block_frames > BW'(ajrb_pkg::BLOCK_MAX)) begin
         frames = BW'(ajrb_pkg::BLOCK_MAX);
      end
   end

   always_comb begin
      excess  = fill_cmp - CW'(target_ff);
      discard = (excess > CW'(trim_ff)) ? CW'(trim_ff) : excess;
   end

   always_comb begin
      state_in       = state_ff;
      read_ptr_in    = read_ptr_ff;
      write_ptr_in   = write_ptr_ff;
      fill_in        = fill_ff;
      buffering_in   = buffering_ff;
      low_written_in = low_written_ff;
      gap_in         = gap_ff;
      silence        = 1'b0;
      pend_add       = '0;
      q_push         = 1'b0;
      q_cmd          = '0;
      ram_wr.en      = 1'b0;
      ram_wr.addr    = write_ptr_ff;
      ram_wr.data    = {req_in_ch3, req_in_ch2, req_in_ch1, req_in_ch0};

      case (state_ff)
         ajrb_pkg::FRONT_IDLE: begin
            if (accept && req_mode == ajrb_pkg::MODE_PUSH) begin
               if (fill_ff < LW'(ajrb_pkg::RING_DEPTH)) begin
                  ram_wr.en    = 1'b1;
                  write_ptr_in = write_ptr_ff + AW'(1);
                  fill_in      = fill_ff + LW'(1);
                  // Prefill slots become real data in address order on the first lap.
                  if (LW'(write_ptr_ff) == low_written_ff
                      && low_written_ff < LW'(ajrb_pkg::PREFILL_LEVEL)) begin
                     low_written_in = low_written_ff + LW'(1);
                  end
                  if (req_burst_end) begin
                     state_in = ajrb_pkg::FRONT_TRIM;
                  end
               end
            end else if (accept) begin
               if (buffering_ff) begin
                  if (fill_cmp >= CW'(target_ff)) begin
                     buffering_in = 1'b0;
                  end else begin
                     silence = 1'b1;
                  end
               end
               if (!silence && fill_cmp < CW'(frames)) begin
                  buffering_in = 1'b1;
                  silence      = 1'b1;
               end
               q_push        = 1'b1;
               q_cmd.base    = read_ptr_ff;
               q_cmd.frames  = frames;
               q_cmd.silent  = silence;
               q_cmd.level   = RW'(fill_ff);
               if (!silence) begin
                  read_ptr_in = read_ptr_ff + AW'(frames);
                  fill_in     = fill_ff - LW'(frames);
                  q_cmd.level = RW'(fill_ff - LW'(frames));
                  pend_add    = PW'(frames);
               end
            end
         end
         ajrb_pkg::FRONT_TRIM: begin
            if (fill_cmp > CW'(high_ff) && fill_cmp > CW'(target_ff)) begin
               read_ptr_in = read_ptr_ff + AW'(discard);
               fill_in     = fill_ff - LW'(discard);
               gap_in      = gap_ff + LW'(discard);
            end
            state_in = ajrb_pkg::FRONT_IDLE;
         end
         default: begin
            state_in = ajrb_pkg::FRONT_IDLE;
         end
      endcase

      pending_in = pending_ff + pend_add - (frame_taken ? PW'(1) : PW'(0));
      if (pending_in == '0) begin
         gap_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ajrb_pkg::FRONT_IDLE;
         read_ptr_ff    <= '0;
         write_ptr_ff   <= AW'(ajrb_pkg::PREFILL % ajrb_pkg::RING_DEPTH);
         fill_ff        <= LW'(ajrb_pkg::PREFILL_LEVEL);
         buffering_ff   <= 1'b0;
         low_written_ff <= '0;
         pending_ff     <= '0;
         gap_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         read_ptr_ff    <= read_ptr_in;
         write_ptr_ff   <= write_ptr_in;
         fill_ff        <= fill_in;
         buffering_ff   <= buffering_in;
         low_written_ff <= low_written_in;
         pending_ff     <= pending_in;
         gap_ff         <= gap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= ajrb_pkg::TARGET_RESET;
         high_ff   <= ajrb_pkg::HIGH_RESET;
         trim_ff   <= ajrb_pkg::TRIM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ajrb_pkg::REG_TARGET: target_ff <= csr_wdata;
            ajrb_pkg::REG_HIGH:   high_ff   <= csr_wdata;
            ajrb_pkg::REG_TRIM:   trim_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign low_written = low_written_ff;

endmodule

### hw/rtl/ajrb_back.sv
`timescale 1ns / 1ps
// Back part: streams one frame per cycle for each queued pull command.
module ajrb_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ajrb_pkg::cmd_type                      q_head,
   input  ajrb_pkg::queue_status_type             q_status,
   output logic                                   q_pop,
   input  logic [ajrb_pkg::LEVEL_W-1:0]           low_written,
   output logic                                   frame_taken,
   output logic                                   rd_en,
   output logic [ajrb_pkg::ADDR_W-1:0]            rd_addr,
   input  logic [ajrb_pkg::FRAME_W-1:0]           rd_data,
   output logic                                   rsp_valid,
   output logic signed [ajrb_pkg::SAMPLE_W-1:0]   rsp_out_ch0,
   output logic signed [ajrb_pkg::SAMPLE_W-1:0]   rsp_out_ch1,
   output logic signed [ajrb_pkg::SAMPLE_W-1:0]   rsp_out_ch2,
   output logic signed [ajrb_pkg::SAMPLE_W-1:0]   rsp_out_ch3,
   output logic                                   rsp_silent,
   output logic                                   rsp_block_last,
   output logic [ajrb_pkg::REG_W-1:0]             rsp_level_after
);

   localparam int AW = ajrb_pkg::ADDR_W;
   localparam int LW = ajrb_pkg::LEVEL_W;
   localparam int BW = ajrb_pkg::BLOCK_W;
   localparam int SW = ajrb_pkg::SAMPLE_W;

   ajrb_pkg::back_state_type state_ff, state_in;
   ajrb_pkg::cmd_type        cmd_ff, cmd_in;
   logic [BW-1:0]            idx_ff, idx_in;

   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_last_ff, s1_last_in;
   logic                       s1_silent_ff, s1_silent_in;
   logic                       s1_zero_ff, s1_zero_in;
   logic [ajrb_pkg::REG_W-1:0] s1_level_ff, s1_level_in;

   logic last;
   logic prefill_slot;

   assign last    = (idx_ff + BW'(1)) == cmd_ff.frames;
   assign rd_addr = cmd_ff.base + AW'(idx_ff);

   // A prefill slot not yet overwritten since reset still reads as silence.
   assign prefill_slot = (LW'(rd_addr) < LW'(ajrb_pkg::PREFILL_LEVEL))
                         && (LW'(rd_addr) >= low_written);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      s1_valid_in  = 1'b0;
      s1_last_in   = last;
      s1_silent_in = cmd_ff.silent;
      s1_zero_in   = cmd_ff.silent || prefill_slot;
      s1_level_in  = cmd_ff.level;

      case (state_ff)
         ajrb_pkg::BACK_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               idx_in   = '0;
               state_in = ajrb_pkg::BACK_RUN;
            end
         end
         ajrb_pkg::BACK_RUN: begin
            rd_en       = !cmd_ff.silent;
            s1_valid_in = 1'b1;
            if (last) begin
               if (!q_status.empty) begin
                  q_pop  = 1'b1;
                  cmd_in = q_head;
                  idx_in = '0;
               end else begin
                  state_in = ajrb_pkg::BACK_IDLE;
               end
            end else begin
               idx_in = idx_ff + BW'(1);
            end
         end
         default: begin
            state_in = ajrb_pkg::BACK_IDLE;
         end
      endcase
   end

   assign frame_taken = rd_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ajrb_pkg::BACK_IDLE;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      s1_last_ff   <= s1_last_in;
      s1_silent_ff <= s1_silent_in;
      s1_zero_ff   <= s1_zero_in;
      s1_level_ff  <= s1_level_in;
   end

   assign rsp_valid       = s1_valid_ff;
   assign rsp_out_ch0     = s1_zero_ff ? '0 : $signed(rd_data[SW-1:0]);
   assign rsp_out_ch1     = s1_zero_ff ? '0 : $signed(rd_data[2*SW-1:SW]);
   assign rsp_out_ch2     = s1_zero_ff ? '0 : $signed(rd_data[3*SW-1:2*SW]);
   assign rsp_out_ch3     = s1_zero_ff ? '0 : $signed(rd_data[4*SW-1:3*SW]);
   assign rsp_silent      = s1_silent_ff;
   assign rsp_block_last  = s1_last_ff;
   assign rsp_level_after = s1_level_ff;

endmodule

### sim/tb_audio_jitter_ring_buffer.sv
`timescale 1ns / 1ps
// Self-checking testbench of the audio jitter ring buffer: directed and random pushes and pulls.
module tb_audio_jitter_ring_buffer;
   import ajrb_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic                  mode;
      logic [SAMPLE_W-1:0]   ch0;
      logic [SAMPLE_W-1:0]   ch1;
      logic [SAMPLE_W-1:0]   ch2;
      logic [SAMPLE_W-1:0]   ch3;
      logic                  burst_end;
      logic [BLOCK_W-1:0]    block_frames;
   } ring_item;

   typedef struct packed {
      logic [SAMPLE_W-1:0]   ch0;
      logic [SAMPLE_W-1:0]   ch1;
      logic [SAMPLE_W-1:0]   ch2;
      logic [SAMPLE_W-1:0]   ch3;
   } sample_set;

   typedef struct packed {
      logic [SAMPLE_W-1:0]   ch0;
      logic [SAMPLE_W-1:0]   ch1;
      logic [SAMPLE_W-1:0]   ch2;
      logic [SAMPLE_W-1:0]   ch3;
      logic                  silent;
      logic                  block_last;
      logic [REG_W-1:0]      level_after;
   } ring_frame;

   class jitter_ring_tracker;
      sample_set ring_mem [RING_DEPTH];
      int        rd_ptr;
      int        wr_ptr;
      int        fill;
      bit        buffering;
      int        target;
      int        high_mark;
      int        trim_max;
      ring_frame due_frames [$];
      int        faults;

      function void clear();
         foreach (ring_mem[i]) ring_mem[i] = '0;
         rd_ptr    = 0;
         wr_ptr    = PREFILL % RING_DEPTH;
         fill      = PREFILL_LEVEL;
         buffering = 0;
         target    = TARGET_RESET;
         high_mark = HIGH_RESET;
         trim_max  = TRIM_RESET;
         due_frames.delete();
         faults    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] value);
         case (idx)
            REG_TARGET: target = value;
            REG_HIGH: high_mark = value;
            REG_TRIM: trim_max = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return due_frames.size();
      endfunction

      // Updates the ring for one accepted item and queues the frames a pull delivers.
      function void take_item(ring_item it);
         int        n;
         int        cut;
         int        k;
         bit        quiet;
         sample_set s;
         ring_frame f;
         if (it.mode == MODE_PUSH) begin
            if (fill >= RING_DEPTH) return;
            ring_mem[wr_ptr] = '{it.ch0, it.ch1, it.ch2, it.ch3};
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            fill++;
            if (it.burst_end && fill > high_mark && fill > target) begin
               cut = fill - target;
               if (cut > trim_max) cut = trim_max;
               rd_ptr = (rd_ptr + cut) % RING_DEPTH;
               fill -= cut;
            end
            return;
         end
         n = it.block_frames;
         if (n == 0) n = 1;
         if (n > BLOCK_MAX) n = BLOCK_MAX;
         quiet = 0;
         if (buffering) begin
            if (fill >= target) buffering = 0;
            else quiet = 1;
         end
         if (!quiet && fill < n) begin
            buffering = 1;
            quiet = 1;
         end
         for (k = 0; k < n; k++) begin
            s = quiet ? '0 : ring_mem[(rd_ptr + k) % RING_DEPTH];
            f.ch0 = s.ch0;
            f.ch1 = s.ch1;
            f.ch2 = s.ch2;
            f.ch3 = s.ch3;
            f.silent = quiet;
            f.block_last = (k == n - 1);
            f.level_after = quiet ? fill[REG_W-1:0] : 16'(fill - n);
            due_frames.push_back(f);
         end
         if (!quiet) begin
            rd_ptr = (rd_ptr + n) % RING_DEPTH;
            fill -= n;
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            faults++;
         end
      endfunction

      function void check_frame(ring_frame got);
         ring_frame want;
         if (due_frames.size() == 0) begin
            $display("%0t: frame with no pull waiting for it, got %0h", $time, got);
            faults++;
            return;
         end
         want = due_frames.pop_front();
         compare_field("out_ch0", want.ch0, got.ch0);
         compare_field("out_ch1", want.ch1, got.ch1);
         compare_field("out_ch2", want.ch2, got.ch2);
         compare_field("out_ch3", want.ch3, got.ch3);
         compare_field("silent", want.silent, got.silent);
         compare_field("block_last", want.block_last, got.block_last);
         compare_field("level_after", want.level_after, got.level_after);
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_mode;
   logic [SAMPLE_W-1:0]  req_in_ch0;
   logic [SAMPLE_W-1:0]  req_in_ch1;
   logic [SAMPLE_W-1:0]  req_in_ch2;
   logic [SAMPLE_W-1:0]  req_in_ch3;
   logic                 req_burst_end;
   logic [BLOCK_W-1:0]   req_block_frames;
   logic                 rsp_valid;
   logic [SAMPLE_W-1:0]  rsp_out_ch0;
   logic [SAMPLE_W-1:0]  rsp_out_ch1;
   logic [SAMPLE_W-1:0]  rsp_out_ch2;
   logic [SAMPLE_W-1:0]  rsp_out_ch3;
   logic                 rsp_silent;
   logic                 rsp_block_last;
   logic [REG_W-1:0]     rsp_level_after;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0]     csr_wdata;

   jitter_ring_tracker tracker;
   bit                 steady;

   audio_jitter_ring_buffer dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_in_ch0       (req_in_ch0),
      .req_in_ch1       (req_in_ch1),
      .req_in_ch2       (req_in_ch2),
      .req_in_ch3       (req_in_ch3),
      .req_burst_end    (req_burst_end),
      .req_block_frames (req_block_frames),
      .rsp_valid        (rsp_valid),
      .rsp_out_ch0      (rsp_out_ch0),
      .rsp_out_ch1      (rsp_out_ch1),
      .rsp_out_ch2      (rsp_out_ch2),
      .rsp_out_ch3      (rsp_out_ch3),
      .rsp_silent       (rsp_silent),
      .rsp_block_last   (rsp_block_last),
      .rsp_level_after  (rsp_level_after),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb_audio_jitter_ring_buffer NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         tracker.check_frame('{rsp_out_ch0, rsp_out_ch1, rsp_out_ch2, rsp_out_ch3,
                               rsp_silent, rsp_block_last, rsp_level_after});
      end
   end

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(7))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'h000000;
         3: return 24'hFFFFFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic ring_item make_push(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                                          logic [SAMPLE_W-1:0] c, logic [SAMPLE_W-1:0] d,
                                          bit burst);
      ring_item it;
      it.mode = MODE_PUSH;
      it.ch0 = a;
      it.ch1 = b;
      it.ch2 = c;
      it.ch3 = d;
      it.burst_end = burst;
      it.block_frames = BLOCK_W'($urandom);
      return it;
   endfunction

   function automatic ring_item rand_push(bit burst);
      return make_push(rand_sample(), rand_sample(), rand_sample(), rand_sample(), burst);
   endfunction

   // Pulls still carry random samples and burst flags, which the block must ignore.
   function automatic ring_item make_pull(int n);
      ring_item it;
      it = rand_push($urandom_range(1));
      it.mode = MODE_PULL;
      it.block_frames = BLOCK_W'(n);
      return it;
   endfunction

   function automatic int rand_block();
      if ($urandom_range(7) == 0) return $urandom_range(0, 127);
      return $urandom_range(1, 12);
   endfunction

   task automatic send(ring_item it);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 36) begin
         start = 0;
         @(negedge clock);
      end
      req_mode = it.mode;
      req_in_ch0 = it.ch0;
      req_in_ch1 = it.ch1;
      req_in_ch2 = it.ch2;
      req_in_ch3 = it.ch3;
      req_burst_end = it.burst_end;
      req_block_frames = it.block_frames;
      start = 1;
      do @(posedge clock); while (busy);
      tracker.take_item(it);
   endtask

   // Stops sending and lets every expected frame arrive, then lets a trim in flight finish.
   task automatic quiesce();
      @(negedge clock);
      start = 0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] value);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = value;
      tracker.write_reg(idx, value);
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic set_regs(int tgt, int high, int trim);
      quiesce();
      write_reg(REG_TARGET, REG_W'(tgt));
      write_reg(REG_HIGH, REG_W'(high));
      write_reg(REG_TRIM, REG_W'(trim));
   endtask

   // Mostly bursts of pushes closed by a burst end and followed by pulls; the rest is noise.
   task automatic run_setting(int tgt, int high, int trim, int count, bit no_gaps);
      int sent;
      int len;
      int i;
      set_regs(tgt, high, trim);
      steady = no_gaps;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) < 7) begin
            len = $urandom_range(1, 14);
            for (i = 0; i < len; i++) send(rand_push(i == len - 1));
            sent += len;
            len = $urandom_range(1, 2);
            for (i = 0; i < len; i++) send(make_pull(rand_block()));
            sent += len;
         end else if ($urandom_range(1) == 1) begin
            send(rand_push($urandom_range(1)));
            sent++;
         end else begin
            send(make_pull($urandom_range(0, 127)));
            sent++;
         end
      end
      steady = 0;
   endtask

   initial begin
      tracker = new;
      tracker.clear();
      steady = 0;
      reset = 1;
      start = 0;
      req_mode = MODE_PUSH;
      req_in_ch0 = '0;
      req_in_ch1 = '0;
      req_in_ch2 = '0;
      req_in_ch3 = '0;
      req_burst_end = 0;
      req_block_frames = '0;
      csr_we = 0;
      csr_index = REG_TARGET;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // The prefilled ring reads as zeros; a size of zero means one frame, large sizes saturate.
      send(make_pull(0));
      send(make_pull(127));
      send(make_pull(65));
      send(make_pull(64));
      send(make_push(24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 0));
      send(make_push(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h000000, 1));

      // A huge trim drops all but the last prefill slot, so the pushed frames follow it.
      set_regs(4, 40, 32768);
      write_reg(REG_SPARE, 16'hFFFF);
      send(make_push(24'hA5A5A5, 24'h5A5A5A, 24'h123456, 24'hEDCBA9, 1));
      send(make_pull(4));
      send(make_pull(1));
      send(rand_push(0));
      send(rand_push(0));
      send(make_pull(2));

      // With the high mark at zero, a burst end at or below the target trims nothing.
      set_regs(4, 0, 32768);
      send(rand_push(1));
      send(rand_push(0));
      send(rand_push(1));
      send(make_pull(3));
      send(make_pull(2));

      run_setting(32, 48, 8, 80, 0);
      run_setting(0, 0, 0, 78, 0);
      run_setting(16, 16, 32768, 78, 1);
      run_setting($urandom_range(0, 80), $urandom_range(0, 160), $urandom_range(0, 40), 78, 0);
      run_setting(100, 200, 64, 78, 0);

      set_regs(0, 0, 32768);
      send(rand_push(1));
      send(make_pull(1));

      quiesce();
      if (tracker.faults == 0 && tracker.pending() == 0) begin
         $display("tb_audio_jitter_ring_buffer OK");
      end else begin
         $display("tb_audio_jitter_ring_buffer NOT OK");
      end
      $finish;
   end

endmodule
